// ----- design/lkv_pkg.sv -----
// Package: shared status codes and sequencer state type for the LRU key/value cache.
package lkv_pkg;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_LONG = 2'd2
  } lkv_status_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SCAN  = 9'b000000010,
    S_MRU   = 9'b000000100,
    S_CP_RD = 9'b000001000,
    S_CP_WR = 9'b000010000,
    S_G_LEN = 9'b000100000,
    S_G_RD  = 9'b001000000,
    S_G_OUT = 9'b010000000,
    S_OUT1  = 9'b100000000
  } lkv_state_t;

endpackage

// ----- design/lkv_in_if.sv -----
// Interface: input request channel (put byte items and get requests).
interface lkv_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] lookup_key;
  logic [7:0]  value_byte;
  logic        byte_present;
  logic        run_end;

  modport source (output valid, func, lookup_key, value_byte, byte_present, run_end,
                  input ready);
  modport sink   (input valid, func, lookup_key, value_byte, byte_present, run_end,
                  output ready);
endinterface

// ----- design/lkv_out_if.sv -----
// Interface: result channel of the LRU key/value cache.
interface lkv_out_if import lkv_pkg::*;;
  logic        valid;
  logic        ready;
  lkv_status_t status;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic [4:0]  out_length;
  logic        out_last;

  modport source (output valid, status, out_byte, out_byte_valid, out_length, out_last,
                  input ready);
  modport sink   (input valid, status, out_byte, out_byte_valid, out_length, out_last,
                  output ready);
endinterface

// ----- design/lkv_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
module lkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- design/lru_key_value_cache.sv -----
// Top level: fully associative key/value cache with LRU replacement.
//
// Usage:
//   in_ch carries put byte items (func 0) and get requests (func 1); out_ch
//   carries results. A word moves when valid and ready are both high.
//   A put run is a series of byte words closed by run_end; the key of the
//   closing word is stored. The closing word gives one result (ok with the
//   length, or too long). A get gives one miss word, one word for an empty
//   value, or one word per stored byte with out_last on the final one.
// Timing:
//   The key scan reads one slot a cycle through the key RAM port, and each
//   value byte passes a read state and then a write or output state on the
//   byte RAM port. in_ch.ready is high only between items.
// Reset: all slots invalid, slot i has rank i, staging empty. No clearing
//   pass. A stalled receiver holds the output register and the sequencer
//   waits; nothing is dropped.
module lru_key_value_cache import lkv_pkg::*; #(
  parameter int ENTRIES         = 16,
  parameter int BYTES_PER_ENTRY = 32
) (
  input  logic clk,
  input  logic rst_n,
  lkv_in_if.sink    in_ch,
  lkv_out_if.source out_ch
);
  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(BYTES_PER_ENTRY + 1);
  localparam int LW = $clog2(BYTES_PER_ENTRY);
  localparam int AW = $clog2(ENTRIES * BYTES_PER_ENTRY);
  localparam logic [IW-1:0] LAST_RANK = IW'(ENTRIES - 1);

  lkv_state_t state_r, state_nxt;

  logic          valid_r [ENTRIES];
  logic [IW-1:0] rank_r  [ENTRIES];

  logic [CW-1:0] count_r, count_nxt;
  logic [63:0]   key_r, key_nxt;
  logic          get_r, get_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] ci_r, ci_nxt;
  logic [IW-1:0] scan_r, scan_nxt;
  logic [IW-1:0] chk_idx_r, chk_idx_nxt;
  logic          chk_r, chk_nxt;
  logic          issued_r, issued_nxt;
  logic [IW-1:0] lru_r, lru_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  logic [IW-1:0] hrank_r, hrank_nxt;
  lkv_status_t   pst_r, pst_nxt;
  logic [LW-1:0] plen_r, plen_nxt;

  logic          out_valid_r, out_valid_nxt;
  lkv_status_t   out_st_r, out_st_nxt;
  logic [7:0]    out_b_r, out_b_nxt;
  logic          out_bv_r, out_bv_nxt;
  logic [4:0]    out_len_r, out_len_nxt;
  logic          out_last_r, out_last_nxt;

  logic          out_free;
  logic          accept;
  logic          stg_we;
  logic [7:0]    stg_rdata;
  logic [CW-1:0] cnt_after;
  logic          key_we;
  logic [63:0]   key_rdata;
  logic [LW-1:0] len_rdata;
  logic          byte_we;
  logic [7:0]    byte_rdata;
  logic [AW-1:0] byte_addr;
  logic          touch;
  logic          set_valid;
  logic          hit;
  logic [IW-1:0] lru_cand;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept    = in_ch.valid && in_ch.ready;
  assign stg_we    = accept && !in_ch.func && in_ch.byte_present &&
                     (count_r < CW'(BYTES_PER_ENTRY));
  assign cnt_after = stg_we ? count_r + 1'b1 : count_r;
  assign byte_addr = AW'(slot_r) * AW'(BYTES_PER_ENTRY) + AW'(ci_r);
  assign hit       = valid_r[chk_idx_r] && (key_rdata == key_r);
  assign lru_cand  = (rank_r[chk_idx_r] == LAST_RANK) ? chk_idx_r : lru_r;

  lkv_ram #(.WIDTH(8), .DEPTH(BYTES_PER_ENTRY)) u_stage (
    .clk(clk), .we(stg_we), .waddr(count_r[LW-1:0]), .wdata(in_ch.value_byte),
    .raddr(ci_r), .rdata(stg_rdata)
  );

  lkv_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_keys (
    .clk(clk), .we(key_we), .waddr(slot_r), .wdata(key_r),
    .raddr(scan_r), .rdata(key_rdata)
  );

  lkv_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_lens (
    .clk(clk), .we(key_we), .waddr(slot_r), .wdata(len_r),
    .raddr(slot_r), .rdata(len_rdata)
  );

  lkv_ram #(.WIDTH(8), .DEPTH(ENTRIES * BYTES_PER_ENTRY)) u_bytes (
    .clk(clk), .we(byte_we), .waddr(byte_addr), .wdata(stg_rdata),
    .raddr(byte_addr), .rdata(byte_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    key_nxt      = key_r;
    get_nxt      = get_r;
    len_nxt      = len_r;
    ci_nxt       = ci_r;
    scan_nxt     = scan_r;
    chk_idx_nxt  = chk_idx_r;
    chk_nxt      = chk_r;
    issued_nxt   = issued_r;
    lru_nxt      = lru_r;
    slot_nxt     = slot_r;
    hrank_nxt    = hrank_r;
    pst_nxt      = pst_r;
    plen_nxt     = plen_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
    out_st_nxt   = out_st_r;
    out_b_nxt    = out_b_r;
    out_bv_nxt   = out_bv_r;
    out_len_nxt  = out_len_r;
    out_last_nxt = out_last_r;
    key_we       = 1'b0;
    byte_we      = 1'b0;
    touch        = 1'b0;
    set_valid    = 1'b0;

    case (state_r)
      S_IDLE: begin
        scan_nxt   = '0;
        chk_nxt    = 1'b0;
        issued_nxt = 1'b0;
        lru_nxt    = '0;
        if (accept) begin
          key_nxt = in_ch.lookup_key;
          get_nxt = in_ch.func;
          if (in_ch.func) begin
            state_nxt = S_SCAN;
          end else begin
            count_nxt = cnt_after;
            if (in_ch.run_end) begin
              count_nxt = '0;
              if (cnt_after >= CW'(BYTES_PER_ENTRY)) begin
                pst_nxt   = ST_LONG;
                plen_nxt  = '0;
                state_nxt = S_OUT1;
              end else begin
                len_nxt   = LW'(cnt_after);
                state_nxt = S_SCAN;
              end
            end
          end
        end
      end
      S_SCAN: begin
        // address of slot n issued in the cycle before its compare
        chk_nxt     = !issued_r;
        chk_idx_nxt = scan_r;
        if (!issued_r) begin
          if (scan_r == LAST_RANK) begin
            issued_nxt = 1'b1;
          end else begin
            scan_nxt = scan_r + 1'b1;
          end
        end
        if (chk_r) begin
          lru_nxt = lru_cand;
          if (hit) begin
            slot_nxt  = chk_idx_r;
            hrank_nxt = rank_r[chk_idx_r];
            state_nxt = S_MRU;
          end else if (chk_idx_r == LAST_RANK) begin
            if (get_r) begin
              pst_nxt   = ST_MISS;
              plen_nxt  = '0;
              state_nxt = S_OUT1;
            end else begin
              slot_nxt  = lru_cand;
              hrank_nxt = LAST_RANK;
              state_nxt = S_MRU;
            end
          end
        end
      end
      S_MRU: begin
        touch  = 1'b1;
        ci_nxt = '0;
        if (get_r) begin
          state_nxt = S_G_LEN;
        end else begin
          key_we    = 1'b1;
          set_valid = 1'b1;
          pst_nxt   = ST_OK;
          plen_nxt  = len_r;
          state_nxt = (len_r == '0) ? S_OUT1 : S_CP_RD;
        end
      end
      S_CP_RD: begin
        state_nxt = S_CP_WR;
      end
      S_CP_WR: begin
        byte_we = 1'b1;
        if (ci_r == LW'(len_r - 1'b1)) begin
          state_nxt = S_OUT1;
        end else begin
          ci_nxt    = ci_r + 1'b1;
          state_nxt = S_CP_RD;
        end
      end
      S_G_LEN: begin
        len_nxt = len_rdata;
        if (len_rdata == '0) begin
          pst_nxt   = ST_OK;
          plen_nxt  = '0;
          state_nxt = S_OUT1;
        end else begin
          state_nxt = S_G_RD;
        end
      end
      S_G_RD: begin
        state_nxt = S_G_OUT;
      end
      S_G_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = ST_OK;
          out_b_nxt     = byte_rdata;
          out_bv_nxt    = 1'b1;
          out_len_nxt   = 5'(len_r);
          out_last_nxt  = (ci_r == LW'(len_r - 1'b1));
          if (ci_r == LW'(len_r - 1'b1)) begin
            state_nxt = S_IDLE;
          end else begin
            ci_nxt    = ci_r + 1'b1;
            state_nxt = S_G_RD;
          end
        end
      end
      S_OUT1: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = pst_r;
          out_b_nxt     = '0;
          out_bv_nxt    = 1'b0;
          out_len_nxt   = 5'(plen_r);
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      chk_r       <= 1'b0;
      issued_r    <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
        rank_r[i]  <= IW'(i);
      end
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      chk_r       <= chk_nxt;
      issued_r    <= issued_nxt;
      if (set_valid) begin
        valid_r[slot_r] <= 1'b1;
      end
      if (touch) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (IW'(i) == slot_r) begin
            rank_r[i] <= '0;
          end else if (rank_r[i] < hrank_r) begin
            rank_r[i] <= rank_r[i] + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    get_r      <= get_nxt;
    len_r      <= len_nxt;
    ci_r       <= ci_nxt;
    scan_r     <= scan_nxt;
    chk_idx_r  <= chk_idx_nxt;
    lru_r      <= lru_nxt;
    slot_r     <= slot_nxt;
    hrank_r    <= hrank_nxt;
    pst_r      <= pst_nxt;
    plen_r     <= plen_nxt;
    out_st_r   <= out_st_nxt;
    out_b_r    <= out_b_nxt;
    out_bv_r   <= out_bv_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_st_r;
  assign out_ch.out_byte       = out_b_r;
  assign out_ch.out_byte_valid = out_bv_r;
  assign out_ch.out_length     = out_len_r;
  assign out_ch.out_last       = out_last_r;

`ifndef SYNTH
  a_staging_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(BYTES_PER_ENTRY))
    else $error("staging count past capacity");

  a_touch_mru: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MRU) |=> (rank_r[slot_r] == '0))
    else $error("touched slot not most recent");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready)
    else $error("input taken while busy");

  a_put_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MRU && !get_r) |=> valid_r[slot_r])
    else $error("stored slot not valid");
`endif
endmodule

// ----- test/lkv_cache_checker.sv -----
// Checker: tracks the cache contents, predicts each result word and compares it.
`timescale 1ns / 100ps

module lkv_cache_checker import lkv_pkg::*; #(
  parameter int ENTRIES         = 16,
  parameter int BYTES_PER_ENTRY = 32
) (
  input  logic clk,
  input  logic rst_n,
  lkv_in_if    in_mon,
  lkv_out_if   out_mon,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    lkv_status_t status;
    logic [7:0]  data;
    logic        data_valid;
    logic [4:0]  length;
    logic        last;
  } result_word_t;

  result_word_t expected_words[$];

  logic        slot_used [ENTRIES];
  logic [63:0] slot_tag  [ENTRIES];
  int          slot_len  [ENTRIES];
  logic [7:0]  slot_data [ENTRIES][BYTES_PER_ENTRY];
  int          slot_age  [ENTRIES];
  logic [7:0]  stage_data [BYTES_PER_ENTRY];
  int          stage_len;

  function automatic int find_tag(logic [63:0] tag);
    for (int i = 0; i < ENTRIES; i++)
      if (slot_used[i] && slot_tag[i] == tag) return i;
    return -1;
  endfunction

  function automatic int oldest_slot();
    int best;
    best = 0;
    for (int i = 1; i < ENTRIES; i++)
      if (slot_age[i] > slot_age[best]) best = i;
    return best;
  endfunction

  task automatic touch_slot(int s);
    int r;
    r = slot_age[s];
    for (int i = 0; i < ENTRIES; i++)
      if (slot_age[i] < r) slot_age[i]++;
    slot_age[s] = 0;
  endtask

  task automatic push_word(lkv_status_t st, logic [7:0] d, logic dv, int len, logic lst);
    result_word_t w;
    w.status     = st;
    w.data       = d;
    w.data_valid = dv;
    w.length     = len[4:0];
    w.last       = lst;
    expected_words.push_back(w);
  endtask

  task automatic apply_request(logic fn, logic [63:0] tag, logic [7:0] b, logic has_b,
                               logic close);
    int s;
    int len;
    if (!fn) begin
      if (has_b && stage_len < BYTES_PER_ENTRY) begin
        stage_data[stage_len] = b;
        stage_len++;
      end
      if (!close) return;
      len = stage_len;
      stage_len = 0;
      if (len >= BYTES_PER_ENTRY) begin
        push_word(ST_LONG, 8'd0, 1'b0, 0, 1'b1);
        return;
      end
      s = find_tag(tag);
      if (s < 0) s = oldest_slot();
      touch_slot(s);
      slot_used[s] = 1'b1;
      slot_tag[s]  = tag;
      slot_len[s]  = len;
      for (int i = 0; i < len; i++) slot_data[s][i] = stage_data[i];
      push_word(ST_OK, 8'd0, 1'b0, len, 1'b1);
      return;
    end
    s = find_tag(tag);
    if (s < 0) begin
      push_word(ST_MISS, 8'd0, 1'b0, 0, 1'b1);
      return;
    end
    touch_slot(s);
    len = slot_len[s];
    if (len == 0) push_word(ST_OK, 8'd0, 1'b0, 0, 1'b1);
    for (int i = 0; i < len; i++)
      push_word(ST_OK, slot_data[s][i], 1'b1, len, i == len - 1);
  endtask

  always @(posedge clk) begin
    result_word_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_used[i] = 1'b0;
        slot_age[i]  = i;
      end
      stage_len = 0;
      expected_words.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.status     = out_mon.status;
        got.data       = out_mon.out_byte;
        got.data_valid = out_mon.out_byte_valid;
        got.length     = out_mon.out_length;
        got.last       = out_mon.out_last;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word: got %p", $time, got);
          errors <= errors + 1;
        end else begin
          want = expected_words.pop_front();
          if (got.status !== want.status || got.data !== want.data ||
              got.data_valid !== want.data_valid || got.length !== want.length ||
              got.last !== want.last) begin
            $display("%0t: result mismatch: expected %p, actual %p", $time, want, got);
            errors <= errors + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        apply_request(in_mon.func, in_mon.lookup_key, in_mon.value_byte,
                      in_mon.byte_present, in_mon.run_end);
      pending <= expected_words.size();
    end
  end

endmodule

// ----- test/lru_key_value_cache_test.sv -----
// Testbench top: drives request words into the cache and gives the verdict.
`timescale 1ns / 100ps

module lru_key_value_cache_test;
  import lkv_pkg::*;

  localparam int ENTRIES     = 16;
  localparam int BYTES_PER   = 32;
  localparam int WORD_TARGET = 230;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  lkv_in_if  req_ch ();
  lkv_out_if res_ch ();

  lru_key_value_cache #(.ENTRIES(ENTRIES), .BYTES_PER_ENTRY(BYTES_PER)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(req_ch.sink), .out_ch(res_ch.source)
  );

  int errors, pending;
  lkv_cache_checker #(.ENTRIES(ENTRIES), .BYTES_PER_ENTRY(BYTES_PER)) checker_i (
    .clk(clk), .rst_n(rst_n), .in_mon(req_ch), .out_mon(res_ch),
    .errors(errors), .pending(pending)
  );

  int  send_gap_pct  = 0;
  int  stall_pct     = 0;
  int  hold_requests = 0;
  int  words_sent    = 0;
  int  results_seen  = 0;
  logic req_fire = 1'b0;
  logic [63:0] key_pool [20];

  always @(posedge clk) begin
    req_fire <= req_ch.valid && req_ch.ready;
    if (res_ch.valid && res_ch.ready) results_seen <= results_seen + 1;
  end

  // receiver: random stalls, plus a long hold whenever the sender asks for one
  initial begin
    int holds_done, hold_left;
    holds_done = 0;
    hold_left  = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time, pending);
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_word(logic fn, logic [63:0] tag, logic [7:0] b, logic has_b,
                           logic close);
    if ($urandom_range(99) < send_gap_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.func         <= fn;
    req_ch.lookup_key   <= tag;
    req_ch.value_byte   <= b;
    req_ch.byte_present <= has_b;
    req_ch.run_end      <= close;
    do @(negedge clk); while (!req_fire);
    words_sent++;
  endtask

  task automatic idle_until_drained();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [63:0] pick_key();
    if ($urandom_range(99) < 6) return {$urandom, $urandom};
    return key_pool[$urandom_range(19)];
  endfunction

  task automatic put_run(logic [63:0] tag, int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 8) send_word(1'b0, pick_key(), 8'($urandom), 1'b0, 1'b0);
      if ($urandom_range(99) < 5)
        send_word(1'b1, pick_key(), 8'($urandom), 1'($urandom), 1'($urandom));
      send_word(1'b0, pick_key(), 8'($urandom), 1'b1, 1'b0);
    end
    send_word(1'b0, tag, 8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int len, phase, roll;
    req_ch.valid        = 1'b0;
    req_ch.func         = 1'b0;
    req_ch.lookup_key   = '0;
    req_ch.value_byte   = '0;
    req_ch.byte_present = 1'b0;
    req_ch.run_end      = 1'b0;
    for (int i = 0; i < 20; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty value, empty hit, miss, get inside a run, overwrite
    send_word(1'b0, 64'd0, 8'h00, 1'b0, 1'b1);
    send_word(1'b1, 64'd0, 8'h00, 1'b0, 1'b0);
    send_word(1'b1, '1, 8'hFF, 1'b1, 1'b1);
    send_word(1'b0, 64'd5, 8'h00, 1'b1, 1'b0);
    send_word(1'b1, 64'd0, 8'hAA, 1'b1, 1'b0);
    send_word(1'b0, 64'd6, 8'hFF, 1'b1, 1'b0);
    send_word(1'b0, 64'd7, 8'h55, 1'b0, 1'b0);
    send_word(1'b0, '1, 8'h5A, 1'b1, 1'b1);
    send_word(1'b1, '1, 8'h00, 1'b0, 1'b0);
    send_word(1'b0, 64'd0, 8'hA5, 1'b1, 1'b1);
    send_word(1'b1, 64'd0, 8'h00, 1'b0, 1'b0);
    idle_until_drained();

    // random run draws on more keys than the table holds, to force evictions
    while (words_sent < WORD_TARGET + 11) begin
      phase = words_sent * 4 / (WORD_TARGET + 11);
      case (phase)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 51; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 51; end
        default: begin send_gap_pct = 13; stall_pct = 13; end
      endcase
      if (phase == 2 && hold_requests == 0) hold_requests = 1;
      roll = $urandom_range(99);
      if (roll < 40) begin
        send_word(1'b1, pick_key(), 8'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        roll = $urandom_range(99);
        if (roll < 75)      len = $urandom_range(0, 5);
        else if (roll < 88) len = $urandom_range(6, BYTES_PER - 1);
        else if (roll < 94) len = BYTES_PER - 1;
        else                len = $urandom_range(BYTES_PER, BYTES_PER + 2);
        put_run(pick_key(), len);
      end
      if ($urandom_range(99) < 3) idle_until_drained();
    end

    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("Covered %0d request words and %0d result words: puts, hits, misses,",
             words_sent, results_seen);
    $display("overlong runs, evictions, gets inside runs, four idle profiles, long hold.");
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
